>>> hw/rtl/great_circle_distance_macros.svh
// Assertion macros shared by the checker of the great circle distance block.
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gcd_pkg.sv
// Shared types, constants and helper functions of the great circle distance block.
`timescale 1ns / 1ps
package gcd_pkg;

  // One CORDIC vector: x, y and angle z, all Q30.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } cvec_t;

  localparam int SQ_STEPS = 31;

  localparam logic [29:0] UDEG_90  = 30'd90000000;
  localparam logic [29:0] UDEG_180 = 30'd180000000;
  localparam logic [29:0] UDEG_360 = 30'd360000000;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_C  = (PI_Q60 + 64'd90000000) / 64'd180000000;
  localparam logic [17:0] RAD_C_LO = RAD_C[17:0];
  localparam logic [16:0] RAD_C_HI = RAD_C[34:18];

  localparam logic [63:0] GAIN_LIMIT_Q30 = 64'd652032874;
  localparam logic [63:0] GAIN_TAIL_Q30  = 64'd434688583;

  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [22:0] TWICE_RADIUS = 23'd7926000;
  localparam logic [23:0] DIST_MAX     = 24'hFF_FFFF;

  // atan(2^-i) in Q30, rounded
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,
    32'd64,        32'd32,        32'd16,        32'd8,
    32'd4,         32'd2,         32'd1,         32'd1
  };

  // Limit a Q30 value to 0..1.0
  function automatic logic [30:0] clamp_unit(input logic signed [32:0] v);
    logic [30:0] res;
    if (v < 33'sd0) begin
      res = '0;
    end else if (v > $signed({2'b00, ONE_Q30})) begin
      res = ONE_Q30;
    end else begin
      res = v[30:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/gcd_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
`timescale 1ns / 1ps
module gcd_cordic #(
  parameter int STAGES    = 24,
  parameter bit VECTORING = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  gcd_pkg::cvec_t  in_vec,
  output logic            out_valid,
  output gcd_pkg::cvec_t  out_vec
);

  gcd_pkg::cvec_t     vec_r [STAGES];
  logic [STAGES-1:0]  vld_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    gcd_pkg::cvec_t     src;
    gcd_pkg::cvec_t     step_nxt;
    logic signed [32:0] xs, ys, zs, dx, dy, at;
    logic               dir;
    logic               vld_in;

    if (i == 0) begin : g_head
      assign src    = in_vec;
      assign vld_in = in_valid;
    end else begin : g_body
      assign src    = vec_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    assign xs = src.x;
    assign ys = src.y;
    assign zs = src.z;
    assign dx = ys >>> i;
    assign dy = xs >>> i;
    assign at = $signed({1'b0, gcd_pkg::ATAN_Q30[i]});

    always_comb begin
      // rotation drives z to zero, vectoring drives y to zero
      dir = VECTORING ? !(ys > 33'sd0) : (zs >= 33'sd0);
      step_nxt.x = dir ? xs - dx : xs + dx;
      step_nxt.y = dir ? ys + dy : ys - dy;
      step_nxt.z = dir ? zs - at : zs + at;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec_r[i] <= step_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_vec   = vec_r[STAGES-1];

endmodule

>>> hw/rtl/great_circle_distance.sv
// Haversine great circle distance, fully pipelined: one item per cycle unless stalled.
// Throughput: one item per clock while the skid register is empty; the CORDIC pipelines and
// the 31-step square root pipelines each retire one item per cycle while not stalled. An
// output skid register keeps in_ready high while one result waits. Synchronous
// active-low reset clears all valid bits.
`timescale 1ns / 1ps
module great_circle_distance #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [27:0] in_first_latitude,
  input  logic signed [28:0] in_first_longitude,
  input  logic signed [27:0] in_second_latitude,
  input  logic signed [28:0] in_second_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_distance_milli_miles
);

  localparam int NS = (CORDIC_STAGES < 1) ? 1 : ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);
  localparam logic [63:0] K_TAIL = (2 * NS < 40)
      ? ((gcd_pkg::GAIN_TAIL_Q30 + (64'd1 << (2 * NS - 1))) >> (2 * NS)) : 64'd0;
  localparam logic [63:0] K_SUM  = gcd_pkg::GAIN_LIMIT_Q30 + K_TAIL;
  localparam logic [32:0] K_INIT = K_SUM[32:0];
  localparam int SQN = gcd_pkg::SQ_STEPS;

  logic pipe_en;

  // ---------------- stage 1: differences and magnitudes
  logic signed [28:0] dlat_nxt;
  logic signed [29:0] dlon_nxt;
  logic        v1_r;
  logic [28:0] dlat_mag_r;
  logic [29:0] dlon_mag_r;
  logic [27:0] lat1_mag_r, lat2_mag_r;

  assign dlat_nxt = $signed({in_second_latitude[27], in_second_latitude})
                  - $signed({in_first_latitude[27], in_first_latitude});
  assign dlon_nxt = $signed({in_second_longitude[28], in_second_longitude})
                  - $signed({in_first_longitude[28], in_first_longitude});

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dlat_mag_r <= dlat_nxt[28] ? 29'(-dlat_nxt) : 29'(dlat_nxt);
      dlon_mag_r <= dlon_nxt[29] ? 30'(-dlon_nxt) : 30'(dlon_nxt);
      lat1_mag_r <= in_first_latitude[27]  ? 28'(-in_first_latitude)  : 28'(in_first_latitude);
      lat2_mag_r <= in_second_latitude[27] ? 28'(-in_second_latitude) : 28'(in_second_latitude);
    end
  end

  // ---------------- stage 2: fold into 0..180 degrees, latitudes into 0..90
  logic [29:0] dlon_m1;
  logic [27:0] fold_nxt [4];
  logic [1:0]  neg_nxt;
  logic        v2_r;
  logic [27:0] ang_m_r [4];
  logic [1:0]  neg2_r;

  always_comb begin
    dlon_m1 = (dlon_mag_r >= gcd_pkg::UDEG_360) ? dlon_mag_r - gcd_pkg::UDEG_360 : dlon_mag_r;
    fold_nxt[0] = (30'(dlat_mag_r) > gcd_pkg::UDEG_180)
                ? 28'(gcd_pkg::UDEG_360 - 30'(dlat_mag_r)) : 28'(dlat_mag_r);
    fold_nxt[1] = (dlon_m1 > gcd_pkg::UDEG_180)
                ? 28'(gcd_pkg::UDEG_360 - dlon_m1) : 28'(dlon_m1);
    neg_nxt[0]  = 30'(lat1_mag_r) > gcd_pkg::UDEG_90;
    neg_nxt[1]  = 30'(lat2_mag_r) > gcd_pkg::UDEG_90;
    fold_nxt[2] = neg_nxt[0] ? 28'(gcd_pkg::UDEG_180 - 30'(lat1_mag_r)) : lat1_mag_r;
    fold_nxt[3] = neg_nxt[1] ? 28'(gcd_pkg::UDEG_180 - 30'(lat2_mag_r)) : lat2_mag_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ang_m_r <= fold_nxt;
      neg2_r  <= neg_nxt;
    end
  end

  // ---------------- stage 3: partial products for degrees to radians
  logic [45:0] plo_nxt [4];
  logic [44:0] phi_nxt [4];
  logic        v3_r;
  logic [45:0] plo_r [4];
  logic [44:0] phi_r [4];
  logic [1:0]  neg3_r;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      plo_nxt[j] = 46'(ang_m_r[j]) * 46'(gcd_pkg::RAD_C_LO);
      phi_nxt[j] = 45'(ang_m_r[j]) * 45'(gcd_pkg::RAD_C_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      neg3_r <= neg2_r;
    end
  end

  // ---------------- stage 4: combine and round to Q30 radians
  // Differences become half angles, latitudes full angles.
  logic [62:0] full_w [4];
  logic [62:0] rnd_w  [4];
  logic [30:0] theta_nxt [4];
  logic        v4_r;
  logic [30:0] theta_r [4];
  logic [1:0]  neg4_r;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      full_w[j] = {phi_r[j], 18'b0} + 63'(plo_r[j]);
      if (j < 2) begin
        rnd_w[j]     = full_w[j] + 63'h4000_0000;
        theta_nxt[j] = rnd_w[j][61:31];
      end else begin
        rnd_w[j]     = full_w[j] + 63'h2000_0000;
        theta_nxt[j] = rnd_w[j][60:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      theta_r <= theta_nxt;
      neg4_r  <= neg3_r;
    end
  end

  // ---------------- rotation CORDICs: sin of half differences, cos of latitudes
  gcd_pkg::cvec_t rot_out [4];
  logic [3:0]     rot_vld;
  logic [1:0]     negd_r [NS];

  for (genvar j = 0; j < 4; j++) begin : g_rot
    gcd_pkg::cvec_t rot_in;
    assign rot_in.x = $signed(K_INIT);
    assign rot_in.y = '0;
    assign rot_in.z = $signed({2'b00, theta_r[j]});

    gcd_cordic #(.STAGES(NS), .VECTORING(1'b0)) u_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (v4_r),
      .in_vec    (rot_in),
      .out_valid (rot_vld[j]),
      .out_vec   (rot_out[j])
    );
  end

  // carry the cosine sign flags alongside the CORDIC
  for (genvar i = 0; i < NS; i++) begin : g_negd
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        negd_r[i] <= (i == 0) ? neg4_r : negd_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // ---------------- stage 5: clamp sines and cosines, apply cosine sign
  logic [30:0]        cu0, cu1;
  logic               v5_r;
  logic [30:0]        sin_r [2];
  logic signed [31:0] cos_r [2];

  assign cu0 = gcd_pkg::clamp_unit(rot_out[2].x);
  assign cu1 = gcd_pkg::clamp_unit(rot_out[3].x);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sin_r[0] <= gcd_pkg::clamp_unit(rot_out[0].y);
      sin_r[1] <= gcd_pkg::clamp_unit(rot_out[1].y);
      cos_r[0] <= negd_r[NS-1][0] ? -$signed({1'b0, cu0}) : $signed({1'b0, cu0});
      cos_r[1] <= negd_r[NS-1][1] ? -$signed({1'b0, cu1}) : $signed({1'b0, cu1});
    end
  end

  // ---------------- stage 6: squares and cosine product
  logic [61:0]        sq0_w, sq1_w;
  logic signed [63:0] ccp_w, ccr_w;
  logic               v6_r;
  logic [30:0]        s1sq_r, s2sq_r;
  logic signed [31:0] cc_r;

  always_comb begin
    sq0_w = 62'(sin_r[0]) * 62'(sin_r[0]) + 62'h2000_0000;
    sq1_w = 62'(sin_r[1]) * 62'(sin_r[1]) + 62'h2000_0000;
    ccp_w = cos_r[0] * cos_r[1];
    ccr_w = ccp_w + 64'sh2000_0000;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1sq_r <= sq0_w[60:30];
      s2sq_r <= sq1_w[60:30];
      cc_r   <= ccr_w[61:30];
    end
  end

  // ---------------- stage 7: cosine product times longitude term
  logic signed [63:0] tp_w, tr_w;
  logic               v7_r;
  logic [30:0]        s1sq7_r;
  logic signed [31:0] t_r;

  always_comb begin
    tp_w = cc_r * $signed({1'b0, s2sq_r});
    tr_w = tp_w + 64'sh2000_0000;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1sq7_r <= s1sq_r;
      t_r     <= tr_w[61:30];
    end
  end

  // ---------------- stage 8: a clamped to 0..1, and 1 - a
  logic signed [32:0] asum_w;
  logic [30:0]        a_w;
  logic               v8_r;
  logic [30:0]        rad_r [2];

  always_comb begin
    asum_w = $signed({2'b00, s1sq7_r}) + $signed({t_r[31], t_r});
    a_w    = gcd_pkg::clamp_unit(asum_w);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rad_r[0] <= a_w;
      rad_r[1] <= gcd_pkg::ONE_Q30 - a_w;
    end
  end

  // ---------------- square roots: one result bit per stage, two lanes
  logic [61:0]    sq_v_r [2][SQN];
  logic [61:0]    sq_r_r [2][SQN];
  logic [SQN-1:0] sq_vld_r;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < SQN; k++) begin : g_step
      logic [61:0] v_in, r_in, trial, v_nxt, r_nxt;

      if (k == 0) begin : g_first
        assign v_in = {1'b0, rad_r[l], 30'b0};
        assign r_in = '0;
      end else begin : g_next
        assign v_in = sq_v_r[l][k-1];
        assign r_in = sq_r_r[l][k-1];
      end

      assign trial = r_in + (62'd1 << (60 - 2 * k));

      always_comb begin
        if (v_in >= trial) begin
          v_nxt = v_in - trial;
          r_nxt = (r_in >> 1) + (62'd1 << (60 - 2 * k));
        end else begin
          v_nxt = v_in;
          r_nxt = r_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          sq_v_r[l][k] <= v_nxt;
          sq_r_r[l][k] <= r_nxt;
        end
      end
    end
  end

  // ---------------- stage 9: round roots to nearest
  logic        v9_r;
  logic [30:0] root_r [2];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int l = 0; l < 2; l++) begin
        root_r[l] <= sq_r_r[l][SQN-1][30:0]
                   + 31'(sq_v_r[l][SQN-1] > sq_r_r[l][SQN-1]);
      end
    end
  end

  // ---------------- vectoring CORDIC: angle of (sqrt(1-a), sqrt(a))
  gcd_pkg::cvec_t vec_in, vec_out;
  logic           vec_vld;

  assign vec_in.x = $signed({2'b00, root_r[1]});
  assign vec_in.y = $signed({2'b00, root_r[0]});
  assign vec_in.z = '0;

  gcd_cordic #(.STAGES(NS), .VECTORING(1'b1)) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (v9_r),
    .in_vec    (vec_in),
    .out_valid (vec_vld),
    .out_vec   (vec_out)
  );

  // ---------------- stage 10: clamp angle, scale by twice the radius
  logic [31:0] zc_w;
  logic        v10_r;
  logic [54:0] dprod_r;

  assign zc_w = (vec_out.z < 33'sd0) ? 32'd0 : vec_out.z[31:0];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dprod_r <= 55'(zc_w) * 55'(gcd_pkg::TWICE_RADIUS);
    end
  end

  // ---------------- final rounding and saturation
  logic [54:0] drnd_w;
  logic [23:0] fin_d;
  logic        fin_take;

  always_comb begin
    drnd_w = dprod_r + 55'h2000_0000;
    fin_d  = (drnd_w[54:30] > 25'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : drnd_w[53:30];
  end

  // ---------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      v5_r     <= 1'b0;
      v6_r     <= 1'b0;
      v7_r     <= 1'b0;
      v8_r     <= 1'b0;
      sq_vld_r <= '0;
      v9_r     <= 1'b0;
      v10_r    <= 1'b0;
    end else if (pipe_en) begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      v5_r     <= &rot_vld;
      v6_r     <= v5_r;
      v7_r     <= v6_r;
      v8_r     <= v7_r;
      sq_vld_r <= (SQN > 1) ? {sq_vld_r[SQN-2:0], v8_r} : SQN'(v8_r);
      v9_r     <= sq_vld_r[SQN-1];
      v10_r    <= vec_vld;
    end
  end

  // ---------------- output register with skid stage
  logic        out_v_r, skid_v_r;
  logic [23:0] out_d_r, skid_d_r;

  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en;
  assign fin_take = pipe_en && v10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= fin_take;
      end
    end else if (fin_take) begin
      // hold the arriving item while the output stalls
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_d_r <= skid_v_r ? skid_d_r : fin_d;
    end
    if (out_v_r && !out_ready && fin_take) begin
      skid_d_r <= fin_d;
    end
  end

  assign out_valid                = out_v_r;
  assign out_distance_milli_miles = out_d_r;

endmodule

>>> hw/rtl/gcd_checker.sv
// Port-level checker for the great circle distance block and its bind.
`timescale 1ns / 1ps
`include "great_circle_distance_macros.svh"
module gcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_distance_milli_miles
);

  `GCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped")
  `GCD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_distance_milli_miles), "stalled result changed")
  `GCD_ASSERT_NOW(a_ready_cause, !in_ready, $past(out_valid && !out_ready), "input stalled without output stall")
  `GCD_ASSERT_NEXT(a_ready_back, out_ready && in_valid, in_ready, "input stalled while output drains")

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_valid                 (in_valid),
  .in_ready                 (in_ready),
  .out_valid                (out_valid),
  .out_ready                (out_ready),
  .out_distance_milli_miles (out_distance_milli_miles)
);
